/* rtl/hall_pulse_tachometer_ema_macros.svh */
// assertion macros shared by the tachometer rtl
// expects clk and rst_n in the scope of each use
`ifndef HALL_PULSE_TACHOMETER_EMA_MACROS_SVH
`define HALL_PULSE_TACHOMETER_EMA_MACROS_SVH

`ifndef NO_ASSERTIONS

`define HPT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hpt assertion failed");

`define HPT_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("hpt forbidden condition seen");

`else

`define HPT_ASSERT(lbl, prop)

`define HPT_ASSERT_NEVER(lbl, expr)

`endif

`endif

/* rtl/hpt_pkg.sv */
// types, widths and register codes for the hall pulse tachometer
// no dependencies
package hpt_pkg;

    localparam int TIME_W     = 32;
    localparam int CNT_W      = 32;
    localparam int FRAC_BITS  = 8;
    localparam int PPS_W      = 28;
    localparam int RPM_W      = 34;
    localparam int WEIGHT_W   = 9;
    localparam int WEIGHT_FRAC = 8;

    // raw pulse rate: count * 1000 in fixed point, below 2^50
    localparam int PRAW_W     = CNT_W + 10 + FRAC_BITS;
    // shared divider: widest dividend is the raw pulse rate times 60
    localparam int DIV_NUM_W  = PRAW_W + 6;
    localparam int DIV_DEN_W  = TIME_W;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_EDGE = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW   = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PPR      = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHT   = 8'd3;

    localparam logic [19:0]         MIN_EDGE_RST = 20'd1000;
    localparam logic [15:0]         WINDOW_RST   = 16'd250;
    localparam logic [7:0]          PPR_RST      = 8'd2;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 9'd77;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;

    localparam logic [0:0] OP_EDGE = 1'b0;
    localparam logic [0:0] OP_POLL = 1'b1;

    typedef struct packed {
        logic [0:0]        opcode;
        logic [TIME_W-1:0] now_us;
        logic [TIME_W-1:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [PPS_W-1:0] smoothed_pps_q8;
        logic [RPM_W-1:0] smoothed_rpm_q8;
        logic [CNT_W-1:0] window_pulses;
    } out_t;

    typedef struct packed {
        logic [19:0]         min_edge_interval_us;
        logic [15:0]         window_length_ms;
        logic [7:0]          pulses_per_turn;
        logic [WEIGHT_W-1:0] smoothing_weight_q8;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

/* rtl/hpt_cfg.sv */
// configuration register file of the tachometer
// depends on hpt_pkg
module hpt_cfg
    import hpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_value,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MIN_EDGE: cfg_next.min_edge_interval_us = cfg_value[19:0];
                CFG_WINDOW:   cfg_next.window_length_ms     = cfg_value[15:0];
                CFG_PPR:      cfg_next.pulses_per_turn      = cfg_value[7:0];
                CFG_WEIGHT:   cfg_next.smoothing_weight_q8  = cfg_value[WEIGHT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_edge_interval_us <= MIN_EDGE_RST;
            cfg_reg.window_length_ms     <= WINDOW_RST;
            cfg_reg.pulses_per_turn      <= PPR_RST;
            cfg_reg.smoothing_weight_q8  <= WEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/hpt_div.sv */
// shared serial divider, one quotient bit per cycle, rounds half up
// depends on hpt_pkg and the assertion macro header
`include "hall_pulse_tachometer_ema_macros.svh"

module hpt_div
    import hpt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_BITS = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] den_next;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_NUM_W-1:0] quo_next;
    logic [DIV_NUM_W-1:0] quot_reg;
    logic [DIV_NUM_W-1:0] quot_next;

    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W+1:0] diff;
    logic                 fits;
    logic                 round_up;

    // partial remainder with next dividend bit, trial subtract
    assign shifted  = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, den_reg};
    assign fits     = ~diff[DIV_DEN_W+1];
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DIV_NUM_W);
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = req.num;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_next = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            else
            begin
                quot_next = quo_reg + DIV_NUM_W'(round_up);
                done_next = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    `HPT_ASSERT(a_div_start_idle, req.start |-> !busy_reg)
    `HPT_ASSERT(a_div_done_pulse, done_reg |=> !done_reg)
    `HPT_ASSERT(a_div_round_step, (busy_reg && cnt_reg == '0 && !req.start) |=> done_reg)

endmodule

/* rtl/hall_pulse_tachometer_ema.sv */
// top level of the hall pulse tachometer with moving average
// depends on hpt_pkg, hpt_cfg, hpt_div and the assertion macro header
//
// usage:
//   in_valid/in_stall/in_data carry requests: an edge (opcode 0) or a poll
//   (opcode 1), each with microsecond and millisecond time stamps.
//   out_valid/out_stall/out_data return one result per evaluated poll.
//   cfg_valid/cfg_ready/cfg_index/cfg_value write the four settings; ready
//   is always high, writes belong to idle periods.
// timing:
//   edges, and polls that come too early, leave in_stall low, so they may
//   arrive back to back.
//   an evaluated poll takes two passes of the shared serial divider (56
//   quotient bits plus a rounding step each) and two smoothing steps, no
//   pass with a zero window and one with no pulses per turn; in_stall
//   falls in the same cycle as out_valid rises.
// reset:
//   counters, time marks and averages clear to zero, settings return to
//   their defaults, no result is pending.
// stall:
//   a result waits in the output register; a further result waits in the
//   sequencer until the register frees, stalling the input side meanwhile.
`include "hall_pulse_tachometer_ema_macros.svh"

module hall_pulse_tachometer_ema
    import hpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_value
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DIV1  = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_DIV2  = 3'd4;
    localparam logic [2:0] ST_EMA_P = 3'd5;
    localparam logic [2:0] ST_EMA_R = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    localparam int EMA_PROD_W = RPM_W + WEIGHT_W;
    localparam int EMA_SUM_W  = EMA_PROD_W + 1;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [TIME_W-1:0] last_edge_reg;
    logic [TIME_W-1:0] last_edge_next;
    logic [CNT_W-1:0]  pulse_total_reg;
    logic [CNT_W-1:0]  pulse_total_next;
    logic [TIME_W-1:0] last_eval_reg;
    logic [TIME_W-1:0] last_eval_next;
    logic [CNT_W-1:0]  snapshot_reg;
    logic [CNT_W-1:0]  snapshot_next;
    logic [PPS_W-1:0]  pps_avg_reg;
    logic [PPS_W-1:0]  pps_avg_next;
    logic [RPM_W-1:0]  rpm_avg_reg;
    logic [RPM_W-1:0]  rpm_avg_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [CNT_W-1:0]  delta_reg;
    logic [CNT_W-1:0]  delta_next;
    logic [TIME_W-1:0] win_reg;
    logic [TIME_W-1:0] win_next;
    logic [PRAW_W-1:0] pps_raw_reg;
    logic [PRAW_W-1:0] pps_raw_next;
    logic [RPM_W-1:0]  rpm_raw_reg;
    logic [RPM_W-1:0]  rpm_raw_next;
    out_t              out_reg;
    out_t              out_next;

    logic                  in_take;
    logic [TIME_W-1:0]     edge_dt;
    logic [TIME_W-1:0]     poll_win;
    logic [DIV_NUM_W-1:0]  delta_ext;
    logic [DIV_NUM_W-1:0]  pps_num;
    logic [DIV_NUM_W-1:0]  pps_ext;
    logic [DIV_NUM_W-1:0]  rpm_num;
    logic [PPS_W-1:0]      pps_sat;
    logic [WEIGHT_W-1:0]   w_new;
    logic [WEIGHT_W-1:0]   w_keep;
    logic [RPM_W-1:0]      ema_avg;
    logic [RPM_W-1:0]      ema_in;
    logic [EMA_PROD_W-1:0] prod_keep;
    logic [EMA_PROD_W-1:0] prod_new;
    logic [EMA_SUM_W-1:0]  ema_sum;
    logic [RPM_W-1:0]      ema_out;
    logic                  out_free;

    hpt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_value (cfg_value),
        .cfg       (cfg)
    );

    hpt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign edge_dt  = in_data.now_us - last_edge_reg;
    assign poll_win = in_data.now_ms - last_eval_reg;

    // count * 1000, then into Q.8
    assign delta_ext = DIV_NUM_W'(delta_reg);
    assign pps_num   = ((delta_ext << 10) - (delta_ext << 4) - (delta_ext << 3)) << FRAC_BITS;
    // raw pulse rate * 60
    assign pps_ext   = DIV_NUM_W'(pps_raw_reg);
    assign rpm_num   = (pps_ext << 6) - (pps_ext << 2);

    assign pps_sat = (pps_raw_reg[PRAW_W-1:PPS_W] != '0) ? {PPS_W{1'b1}}
                                                           : pps_raw_reg[PPS_W-1:0];

    // shared smoothing step, weight capped at one
    assign w_new   = (cfg.smoothing_weight_q8 > WEIGHT_ONE) ? WEIGHT_ONE
                                                            : cfg.smoothing_weight_q8;
    assign w_keep  = WEIGHT_ONE - w_new;
    assign ema_avg = (state_reg == ST_EMA_P) ? RPM_W'(pps_avg_reg) : rpm_avg_reg;
    assign ema_in  = (state_reg == ST_EMA_P) ? RPM_W'(pps_sat) : rpm_raw_reg;
    assign prod_keep = EMA_PROD_W'(ema_avg) * EMA_PROD_W'(w_keep);
    assign prod_new  = EMA_PROD_W'(ema_in) * EMA_PROD_W'(w_new);
    assign ema_sum   = EMA_SUM_W'(prod_keep) + EMA_SUM_W'(prod_new)
                     + EMA_SUM_W'(1 << (WEIGHT_FRAC - 1));
    assign ema_out   = ema_sum[WEIGHT_FRAC +: RPM_W];

    always_comb
    begin
        state_next       = state_reg;
        last_edge_next   = last_edge_reg;
        pulse_total_next = pulse_total_reg;
        last_eval_next   = last_eval_reg;
        snapshot_next    = snapshot_reg;
        pps_avg_next     = pps_avg_reg;
        rpm_avg_next     = rpm_avg_reg;
        delta_next       = delta_reg;
        win_next         = win_reg;
        pps_raw_next     = pps_raw_reg;
        rpm_raw_next     = rpm_raw_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && out_stall;
        div_req.start    = 1'b0;
        div_req.num      = pps_num;
        div_req.den      = win_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_data.opcode == OP_EDGE)
                    begin
                        if (edge_dt >= TIME_W'(cfg.min_edge_interval_us))
                        begin
                            last_edge_next   = in_data.now_us;
                            pulse_total_next = pulse_total_reg + CNT_W'(1);
                        end
                    end
                    else if (poll_win >= TIME_W'(cfg.window_length_ms))
                    begin
                        last_eval_next = in_data.now_ms;
                        delta_next     = pulse_total_reg - snapshot_reg;
                        snapshot_next  = pulse_total_reg;
                        win_next       = poll_win;
                        state_next     = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                if (win_reg == '0)
                begin
                    pps_raw_next = '0;
                    rpm_raw_next = '0;
                    state_next   = ST_EMA_P;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_rsp.done)
                begin
                    pps_raw_next = div_rsp.quot[PRAW_W-1:0];
                    state_next   = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                div_req.num = rpm_num;
                div_req.den = DIV_DEN_W'(cfg.pulses_per_turn);
                if (cfg.pulses_per_turn == '0)
                begin
                    rpm_raw_next = '0;
                    state_next   = ST_EMA_P;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_rsp.done)
                begin
                    rpm_raw_next = (div_rsp.quot[DIV_NUM_W-1:RPM_W] != '0) ? {RPM_W{1'b1}}
                                                                       : div_rsp.quot[RPM_W-1:0];
                    state_next   = ST_EMA_P;
                end
            end
            ST_EMA_P:
            begin
                pps_avg_next = ema_out[PPS_W-1:0];
                state_next   = ST_EMA_R;
            end
            ST_EMA_R:
            begin
                rpm_avg_next = ema_out;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next.smoothed_pps_q8 = pps_avg_reg;
                    out_next.smoothed_rpm_q8 = rpm_avg_reg;
                    out_next.window_pulses   = delta_reg;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_edge_reg   <= '0;
            pulse_total_reg <= '0;
            last_eval_reg   <= '0;
            snapshot_reg    <= '0;
            pps_avg_reg     <= '0;
            rpm_avg_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_edge_reg   <= last_edge_next;
            pulse_total_reg <= pulse_total_next;
            last_eval_reg   <= last_eval_next;
            snapshot_reg    <= snapshot_next;
            pps_avg_reg     <= pps_avg_next;
            rpm_avg_reg     <= rpm_avg_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg   <= delta_next;
        win_reg     <= win_next;
        pps_raw_reg <= pps_raw_next;
        rpm_raw_reg <= rpm_raw_next;
        out_reg     <= out_next;
    end

    `HPT_ASSERT(a_out_from_emit, $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
    `HPT_ASSERT(a_div_done_in_wait,
        div_rsp.done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
    `HPT_ASSERT(a_pulse_step_one,
        (pulse_total_reg != $past(pulse_total_reg))
            |-> (pulse_total_reg == $past(pulse_total_reg) + CNT_W'(1)))

endmodule

/* dv/tb_top.sv */
// self-checking bench for hall_pulse_tachometer_ema: queue-fed driver, stalling monitor
// and an in-bench rate estimator that predicts every smoothed reading
// depends on hpt_pkg and the rtl of the tachometer
module tb_top;
    import hpt_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SETTLE       = 160;
    localparam int HOLD_CYCLES  = 3000;
    localparam int MAX_IDLE     = 17;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_LOW  = 8'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_HIGH = 8'hFE;
    localparam logic [63:0] PPS_TOP = (64'd1 << PPS_W) - 64'd1;
    localparam logic [63:0] RPM_TOP = (64'd1 << RPM_W) - 64'd1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_t                   in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_t                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_value = '0;

    // settings as the estimator sees them
    logic [19:0]         set_min_edge = MIN_EDGE_RST;
    logic [15:0]         set_window   = WINDOW_RST;
    logic [7:0]          set_ppr      = PPR_RST;
    logic [WEIGHT_W-1:0] set_weight   = WEIGHT_RST;

    // estimator state
    logic [31:0] last_edge_us = '0;
    logic [31:0] pulse_count  = '0;
    logic [31:0] last_eval_ms = '0;
    logic [31:0] pulse_mark   = '0;
    logic [27:0] pps_avg      = '0;
    logic [33:0] rpm_avg      = '0;

    in_t  request_queue[$];
    out_t expected_readings[$];
    int   mismatches = 0;
    int   gap_left   = 0;
    int   stall_left = 0;
    bit   send_calm  = 1'b0;
    bit   recv_calm  = 1'b0;
    bit   hold_kick  = 1'b0;
    logic recv_hold  = 1'b0;
    logic [31:0] base_us = '0;
    logic [31:0] base_ms = '0;

    hall_pulse_tachometer_ema dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_value (cfg_value)
    );

    always #4 clk = ~clk;

    function automatic logic [63:0] div_nearest(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        if (r >= den - r)
            q = q + 64'd1;
        return q;
    endfunction

    task automatic estimate_rates(in_t req);
        logic [31:0] dt;
        logic [31:0] win;
        logic [31:0] delta;
        logic [63:0] praw;
        logic [63:0] rraw;
        logic [63:0] w;
        logic [63:0] pa;
        logic [63:0] ra;
        out_t        reading;
        if (req.opcode == OP_EDGE)
        begin
            dt = req.now_us - last_edge_us;
            if (dt >= {12'd0, set_min_edge})
            begin
                last_edge_us = req.now_us;
                pulse_count  = pulse_count + 32'd1;
            end
        end
        else
        begin
            win = req.now_ms - last_eval_ms;
            if (win >= {16'd0, set_window})
            begin
                last_eval_ms = req.now_ms;
                delta        = pulse_count - pulse_mark;
                pulse_mark   = pulse_count;
                praw = '0;
                rraw = '0;
                if (win != 0)
                begin
                    praw = div_nearest(({32'd0, delta} * 64'd1000) << FRAC_BITS, {32'd0, win});
                    if (set_ppr != 0)
                        rraw = div_nearest(praw * 64'd60, {56'd0, set_ppr});
                end
                if (praw > PPS_TOP)
                    praw = PPS_TOP;
                if (rraw > RPM_TOP)
                    rraw = RPM_TOP;
                w  = (set_weight > WEIGHT_ONE) ? 64'd256 : {55'd0, set_weight};
                pa = ({36'd0, pps_avg} * (64'd256 - w) + praw * w + 64'd128) >> 8;
                ra = ({30'd0, rpm_avg} * (64'd256 - w) + rraw * w + 64'd128) >> 8;
                if (pa > PPS_TOP)
                    pa = PPS_TOP;
                if (ra > RPM_TOP)
                    ra = RPM_TOP;
                pps_avg = pa[PPS_W-1:0];
                rpm_avg = ra[RPM_W-1:0];
                reading.smoothed_pps_q8 = pps_avg;
                reading.smoothed_rpm_q8 = rpm_avg;
                reading.window_pulses   = delta;
                expected_readings.push_back(reading);
            end
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                estimate_rates(in_data);
                gap_left = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left == 0 && request_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= request_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // reading monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected reading: pps %0d rpm %0d pulses %0d",
                                 out_data.smoothed_pps_q8, out_data.smoothed_rpm_q8,
                                 out_data.window_pulses);
                end
                else
                begin
                    if (out_data.smoothed_pps_q8 !== expected_readings[0].smoothed_pps_q8
                        || out_data.smoothed_rpm_q8 !== expected_readings[0].smoothed_rpm_q8
                        || out_data.window_pulses !== expected_readings[0].window_pulses)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("reading mismatch: pps %0d/%0d rpm %0d/%0d pulses %0d/%0d",
                                     expected_readings[0].smoothed_pps_q8,
                                     out_data.smoothed_pps_q8,
                                     expected_readings[0].smoothed_rpm_q8,
                                     out_data.smoothed_rpm_q8,
                                     expected_readings[0].window_pulses,
                                     out_data.window_pulses);
                    end
                    void'(expected_readings.pop_front());
                end
                stall_left = recv_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (recv_hold)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                if (out_valid)
                    stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // long receiver hold-off, started once by the stimulus
    initial
    begin
        wait (hold_kick);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
    end

    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("FAIL hall_pulse_tachometer_ema");
        $finish;
    end

    task automatic write_setting(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_value <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_EDGE: set_min_edge = val;
            CFG_WINDOW:   set_window   = val[15:0];
            CFG_PPR:      set_ppr      = val[7:0];
            CFG_WEIGHT:   set_weight   = val[WEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [19:0] min_edge, logic [15:0] window, logic [7:0] ppr,
                             logic [WEIGHT_W-1:0] weight);
        write_setting(CFG_MIN_EDGE, min_edge);
        write_setting(CFG_WINDOW, {4'd0, window});
        write_setting(CFG_PPR, {12'd0, ppr});
        write_setting(CFG_WEIGHT, {11'd0, weight});
    endtask

    task automatic write_random_settings();
        logic [19:0]         min_edge;
        logic [15:0]         window;
        logic [7:0]          ppr;
        logic [WEIGHT_W-1:0] weight;
        case ($urandom_range(0, 4))
            0:       min_edge = '0;
            1:       min_edge = 20'($urandom_range(1, 40));
            2:       min_edge = 20'd1000;
            3:       min_edge = 20'($urandom_range(0, 20'hFFFFF));
            default: min_edge = 20'hFFFFF;
        endcase
        case ($urandom_range(0, 4))
            0:       window = 16'd1;
            1:       window = 16'($urandom_range(1, 20));
            2:       window = 16'd250;
            3:       window = 16'($urandom_range(0, 16'hFFFF));
            default: window = 16'hFFFF;
        endcase
        case ($urandom_range(0, 4))
            0:       ppr = 8'd1;
            1:       ppr = 8'($urandom_range(1, 255));
            2:       ppr = 8'd2;
            3:       ppr = 8'hFF;
            default: ppr = 8'd0;
        endcase
        case ($urandom_range(0, 4))
            0:       weight = 9'd1;
            1:       weight = WEIGHT_RST;
            2:       weight = WEIGHT_ONE;
            3:       weight = 9'($urandom_range(0, 511));
            default: weight = 9'($urandom_range(1, 255));
        endcase
        write_all(min_edge, window, ppr, weight);
    endtask

    task automatic add_request(logic [0:0] op, logic [31:0] us, logic [31:0] ms);
        in_t req;
        req.opcode = op;
        req.now_us = us;
        req.now_ms = ms;
        request_queue.push_back(req);
    endtask

    // mostly plausible edge and poll timelines around the current settings, some noise
    task automatic add_random(int count, int poll_pct);
        in_t         req;
        int unsigned roll;
        logic [31:0] advance;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
            begin
                req.opcode = $urandom_range(0, 1) ? OP_POLL : OP_EDGE;
                req.now_us = $urandom;
                req.now_ms = $urandom;
                if (req.opcode == OP_EDGE)
                    base_us = req.now_us;
                else
                    base_ms = req.now_ms;
            end
            else if (roll < 6 + poll_pct)
            begin
                case ($urandom_range(0, 3))
                    0:       advance = $urandom_range(0, set_window);
                    1:       advance = set_window;
                    default: advance = set_window + $urandom_range(0, set_window / 2 + 3);
                endcase
                req.opcode = OP_POLL;
                req.now_us = base_us + $urandom_range(0, 7);
                req.now_ms = base_ms + advance;
                if (advance >= set_window)
                    base_ms = req.now_ms;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       advance = $urandom_range(0, set_min_edge);
                    1:       advance = set_min_edge;
                    2:       advance = (set_min_edge == 0) ? 32'd0 : set_min_edge - 32'd1;
                    default: advance = set_min_edge + $urandom_range(0, set_min_edge + 20);
                endcase
                req.opcode = OP_EDGE;
                req.now_us = base_us + advance;
                req.now_ms = base_ms + $urandom_range(0, 3);
                if (advance >= set_min_edge)
                    base_us = req.now_us;
            end
            request_queue.push_back(req);
        end
    endtask

    task automatic wait_idle(int settle);
        @(negedge clk);
        while (request_queue.size() != 0 || in_valid || expected_readings.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset settings: edge spacing limits, wrap of both clocks, early and due polls
        add_request(OP_EDGE, 32'd0, 32'd0);
        add_request(OP_EDGE, 32'd999, 32'd0);
        add_request(OP_EDGE, 32'd1000, 32'd0);
        add_request(OP_EDGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(OP_EDGE, 32'h0000_03E6, 32'd0);
        add_request(OP_EDGE, 32'h0000_03E7, 32'd0);
        add_request(OP_POLL, 32'd0, 32'd249);
        add_request(OP_POLL, 32'd0, 32'd250);
        add_request(OP_POLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(OP_EDGE, 32'h5555_5555, 32'hAAAA_AAAA);
        add_request(OP_EDGE, 32'hAAAA_AAAA, 32'h5555_5555);
        add_request(OP_POLL, 32'hFFFF_FFFF, 32'h0000_00F9);
        wait_idle(SETTLE);

        // zero spacing and window, no pulses per turn, weight above one; unused indexes last
        write_all(20'd0, 16'd0, 8'd0, 9'h1FF);
        write_setting(CFG_UNUSED_LOW, 20'h12345);
        write_setting(CFG_UNUSED_HIGH, 20'hFFFFF);
        add_request(OP_EDGE, 32'h10, 32'd0);
        add_request(OP_EDGE, 32'h10, 32'd0);
        add_request(OP_POLL, 32'd0, 32'hF9);
        add_request(OP_EDGE, 32'h11, 32'd0);
        add_request(OP_POLL, 32'd0, 32'hFA);
        wait_idle(SETTLE);

        // largest settings, zero weight keeps the averages
        write_all(20'hFFFFF, 16'hFFFF, 8'hFF, 9'd0);
        add_request(OP_EDGE, 32'h0010_000F, 32'd0);
        add_request(OP_EDGE, 32'h0010_0010, 32'd0);
        add_request(OP_POLL, 32'd0, 32'h0001_00F8);
        add_request(OP_POLL, 32'd0, 32'h0001_00F9);
        wait_idle(SETTLE);

        base_us = $urandom;
        base_ms = $urandom;
        for (int ph = 0; ph < 8; ph++)
        begin
            send_calm = (ph % 3 == 1);
            recv_calm = (ph % 4 == 2);
            write_random_settings();
            if (ph == 3)
            begin
                send_calm = 1'b1;
                hold_kick = 1'b1;
                add_random(40, 70);
            end
            add_random(16, 25);
            wait_idle(SETTLE);
        end

        // burst of counted edges into a 1 ms window so both rates saturate
        send_calm = 1'b1;
        recv_calm = 1'b0;
        write_all(20'd0, 16'd1, 8'd1, WEIGHT_ONE);
        base_ms = base_ms + 32'd70000;
        add_request(OP_POLL, base_us, base_ms);
        for (int i = 0; i < 1150; i++)
            add_request(OP_EDGE, $urandom, base_ms);
        add_request(OP_POLL, base_us, base_ms + 32'd1);
        wait_idle(SETTLE);

        if (mismatches == 0 && expected_readings.size() == 0)
            $display("PASS hall_pulse_tachometer_ema");
        else
            $display("FAIL hall_pulse_tachometer_ema");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/hpt_pkg.sv
rtl/hpt_cfg.sv
rtl/hpt_div.sv
rtl/hall_pulse_tachometer_ema.sv
dv/tb_top.sv
